// File: rtl/pmp_pkg.sv
// Shared types and constants for the PWM melody player.
// Request/response payload structs, note entry layout and default sizes.
// No dependencies.
package pmp_pkg;

  localparam int DEF_PWM_CLOCK_HZ = 16000000;
  localparam int DEF_NOTE_DEPTH   = 64;

  localparam int PERIOD_W = 24;
  localparam int HIGH_W   = 23;
  localparam int FREQ_W   = 16;
  localparam int MS_W     = 16;
  localparam int SLOT_W   = 7;

  localparam logic [2:0] FUNC_TICK  = 3'd0;
  localparam logic [2:0] FUNC_WRITE = 3'd1;
  localparam logic [2:0] FUNC_START = 3'd2;
  localparam logic [2:0] FUNC_TONE  = 3'd3;
  localparam logic [2:0] FUNC_STOP  = 3'd4;

  typedef struct packed {
    logic [2:0]        func;
    logic [5:0]        note_index;
    logic [FREQ_W-1:0] tone_freq;
    logic [MS_W-1:0]   tone_ms;
    logic [6:0]        melody_len;
  } req_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] pwm_period;
    logic [HIGH_W-1:0]   pwm_high;
    logic                playing;
    logic                note_started;
  } rsp_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [MS_W-1:0]   ms;
  } note_t;

endpackage

// File: rtl/pmp_div.sv
// Iterative restoring divider: constant clock rate divided by a tone frequency.
// One quotient bit per cycle; uses pmp_pkg widths.
module pmp_div #(
  parameter int CLK_HZ = pmp_pkg::DEF_PWM_CLOCK_HZ
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pmp_pkg::FREQ_W-1:0]     divisor,
  output logic                           done,
  output logic [pmp_pkg::PERIOD_W-1:0]   quotient
);
  import pmp_pkg::*;

  localparam int CNT_W = $clog2(PERIOD_W + 1);
  localparam logic [PERIOD_W-1:0] DIVIDEND = PERIOD_W'(CLK_HZ);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [FREQ_W-1:0]   den;
  logic [FREQ_W-1:0]   rem;
  logic [PERIOD_W-1:0] num;
  logic [FREQ_W:0]     rem_sh;
  logic [FREQ_W:0]     diff;
  logic                fits;

  assign rem_sh   = {rem, num[PERIOD_W-1]};
  assign diff     = rem_sh - {1'b0, den};
  assign fits     = rem_sh >= {1'b0, den};
  assign quotient = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(PERIOD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den <= divisor;
      rem <= '0;
      num <= DIVIDEND;
    end else if (busy) begin
      if (fits) begin
        rem <= diff[FREQ_W-1:0];
        num <= {num[PERIOD_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[FREQ_W-1:0];
        num <= {num[PERIOD_W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/pmp_note_mem.sv
// Note table: one synchronous memory of frequency/duration pairs.
// One write port, one registered read port; uses pmp_pkg::note_t.
module pmp_note_mem #(
  parameter int DEPTH = pmp_pkg::DEF_NOTE_DEPTH,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  pmp_pkg::note_t  wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output pmp_pkg::note_t  rdata
);
  import pmp_pkg::*;

  note_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/pwm_melody_player.sv
// PWM melody player top level: request decode, melody sequencer, PWM setting.
// Uses pmp_pkg, pmp_note_mem (note table) and pmp_div (period divider).
//
// Usage:
//   Each request on req_data (valid/stall) carries one command: a 1 ms tick,
//   a note-table write, a melody start, a single tone or a stop. Every request
//   yields exactly one response on rsp_data: the PWM period and high time now
//   in force, whether the tone countdown is running and whether this request
//   began a stored melody note.
//   From acceptance to the response handshake, requests that touch no tone
//   (tick without expiry, note write, stop) pass only the result state. A
//   nonzero play-tone is accepted, runs 24 divider steps, has its quotient
//   taken and then loads the output. A request that takes a stored note
//   (melody start or expiring tick) also passes the note-table read first.
//   One request is in work at a time, so a new request waits for the last;
//   req_stall is high from acceptance until the response is handed to
//   the output register. The output register lets the next request in while
//   an earlier response waits.
//   Reset: countdown and melody counters clear, the output is silent
//   (period = clock / 1000, high time 0). The note table is not cleared.
//   When the receiver holds rsp_stall, the response holds and a finished
//   request waits in its last state until the output register frees.
module pwm_melody_player #(
  parameter int PWM_CLOCK_HZ = pmp_pkg::DEF_PWM_CLOCK_HZ,
  parameter int NOTE_DEPTH   = pmp_pkg::DEF_NOTE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  pmp_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output pmp_pkg::rsp_t rsp_data
);
  import pmp_pkg::*;

  localparam int AW = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;
  localparam logic [PERIOD_W-1:0] SILENT_PERIOD = PERIOD_W'(PWM_CLOCK_HZ / 1000);
  localparam logic [SLOT_W-1:0]   DEPTH_SLOTS   = SLOT_W'(NOTE_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ADV    = 5'b00010,
    S_LOOK   = 5'b00100,
    S_DIV    = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t              state;
  logic [MS_W-1:0]     tone_left;
  logic [SLOT_W-1:0]   next_slot;
  logic [SLOT_W-1:0]   notes_left;
  logic [PERIOD_W-1:0] period_reg;
  logic [HIGH_W-1:0]   high_reg;
  logic [MS_W-1:0]     ms_hold;
  logic                started;

  logic                accept;
  logic                out_free;
  logic [SLOT_W-1:0]   len_sat;

  // note table ports
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  note_t               mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  note_t               mem_rdata;

  // divider ports
  logic                div_start;
  logic [FREQ_W-1:0]   div_divisor;
  logic                div_done;
  logic [PERIOD_W-1:0] div_q;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign len_sat   = (req_data.melody_len > DEPTH_SLOTS) ? DEPTH_SLOTS : req_data.melody_len;

  // Write the note table straight from the request; out-of-range slots drop.
  assign mem_we          = accept && (req_data.func == FUNC_WRITE)
                           && ({1'b0, req_data.note_index} < DEPTH_SLOTS);
  assign mem_waddr       = req_data.note_index[AW-1:0];
  assign mem_wdata.freq  = req_data.tone_freq;
  assign mem_wdata.ms    = req_data.tone_ms;

  // Read the next melody slot; a slot past the table wraps to zero.
  assign mem_re    = (state == S_ADV) && (notes_left != '0);
  assign mem_raddr = (next_slot >= DEPTH_SLOTS) ? '0 : next_slot[AW-1:0];

  // Start the divider from a play-tone request or from a fetched note.
  always_comb begin
    div_start   = 1'b0;
    div_divisor = req_data.tone_freq;
    if (accept && (req_data.func == FUNC_TONE) && (req_data.tone_freq != '0)) begin
      div_start = 1'b1;
    end else if ((state == S_LOOK) && (mem_rdata.freq != '0)) begin
      div_start   = 1'b1;
      div_divisor = mem_rdata.freq;
    end
  end

  pmp_note_mem #(
    .DEPTH (NOTE_DEPTH),
    .AW    (AW)
  ) u_note_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pmp_div #(
    .CLK_HZ (PWM_CLOCK_HZ)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sequencer: decode the request, fetch a note, wait for the divider, report.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tone_left  <= '0;
      next_slot  <= '0;
      notes_left <= '0;
      period_reg <= SILENT_PERIOD;
      high_reg   <= '0;
      started    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            started <= 1'b0;
            state   <= S_RESULT;
            case (req_data.func)
              FUNC_TICK: begin
                if (tone_left != '0) begin
                  tone_left <= tone_left - 1'b1;
                  // countdown expires: silence and take the next note
                  if (tone_left == MS_W'(1)) begin
                    state <= S_ADV;
                  end
                end
              end
              FUNC_START: begin
                next_slot  <= '0;
                notes_left <= len_sat;
                state      <= S_ADV;
              end
              FUNC_TONE: begin
                if (req_data.tone_freq != '0) begin
                  state <= S_DIV;
                end
              end
              FUNC_STOP: begin
                period_reg <= SILENT_PERIOD;
                high_reg   <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_ADV: begin
          period_reg <= SILENT_PERIOD;
          high_reg   <= '0;
          if (notes_left != '0) begin
            next_slot  <= next_slot + 1'b1;
            notes_left <= notes_left - 1'b1;
            state      <= S_LOOK;
          end else begin
            state <= S_RESULT;
          end
        end
        S_LOOK: begin
          // a zero-frequency note is consumed and halts the melody
          if (mem_rdata.freq != '0) begin
            started <= 1'b1;
            state   <= S_DIV;
          end else begin
            state <= S_RESULT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            period_reg <= div_q;
            high_reg   <= div_q[PERIOD_W-1:1];
            tone_left  <= ms_hold;
            state      <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the duration that goes with the pending divide.
  always_ff @(posedge clk) begin
    if (accept) begin
      ms_hold <= req_data.tone_ms;
    end else if (state == S_LOOK) begin
      ms_hold <= mem_rdata.ms;
    end
  end

  // Output register: load the response when free, drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_RESULT) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_RESULT) && out_free) begin
      rsp_data.pwm_period   <= period_reg;
      rsp_data.pwm_high     <= high_reg;
      rsp_data.playing      <= (tone_left != '0);
      rsp_data.note_started <= started;
    end
  end

  // High time is either silent or exactly half the period.
  a_high_half : assert property (@(posedge clk) disable iff (rst)
    (high_reg == '0) || (high_reg == period_reg[PERIOD_W-1:1]))
    else $error("PWM high time is not half the period");

  // The melody never runs past the end of the note table.
  a_slot_bound : assert property (@(posedge clk) disable iff (rst)
    ({1'b0, next_slot} + {1'b0, notes_left}) <= {1'b0, DEPTH_SLOTS})
    else $error("melody slot range exceeds note table");

  // A divider result only arrives while the sequencer waits for it.
  a_div_done : assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

  // An accepted request always leaves idle on the next cycle.
  a_leave_idle : assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("accepted request did not start processing");

endmodule
